>>> rtl/core/dsqrt_pkg.sv
// Shared widths, reset values and state encoding for the decimal square root block.
`timescale 1ns / 1ps

package dsqrt_pkg;

  // Field widths of the stream payloads.
  localparam int RADICAND_W  = 31;
  localparam int INT_ROOT_W  = 16;
  localparam int SCALED_W    = 36;
  localparam int DIGITS_W    = 3;

  // Packed bus widths, padded to whole bytes.
  localparam int S_TDATA_W   = 32;
  localparam int M_TDATA_W   = 56;

  // Radicand width seen by the integer root unit (two bits per iteration).
  localparam int INT_RAD_W   = 2 * INT_ROOT_W;
  localparam int INT_CNT_W   = 5;

  localparam logic [DIGITS_W-1:0] DIGITS_RESET = 3'd3;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCALE = 4'b0010,
    ST_ROOT  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

endpackage

>>> rtl/core/decimal_square_root.sv
// Top level of the decimal square root: scaling, bit-serial roots and stream ports.
`timescale 1ns / 1ps

// The main root loop, after scaling by 100^d where d is the saturated digit
// count, retires one root bit per cycle; ROOT_W is 36 for MAX_DIGITS = 6.
// A new request is accepted only while the sequencer is idle.
// A finished result waits in the output register while the next request runs.
// Reset is asynchronous and active low; it idles the sequencer, drops the
// output valid and sets the digit count register to 3.
module decimal_square_root #(
  parameter int MAX_DIGITS = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration: number of decimal fraction digits.
  input  logic                             cfg_wr_en_i,
  input  logic [dsqrt_pkg::DIGITS_W-1:0]   cfg_wr_data_i,
  // Request stream. tdata: [30:0] radicand, [31] zero.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [dsqrt_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // Result stream. tdata: [15:0] integer_root, [51:16] scaled_root, [55:52] zero.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [dsqrt_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

  // Bits of 100^MAX_DIGITS, from log2(10) ~ 3.322; the product is never an integer.
  localparam int SCALE_BITS = (2 * MAX_DIGITS * 3322 + 999) / 1000;
  localparam int RAW_W      = dsqrt_pkg::RADICAND_W + SCALE_BITS;
  // The scaled radicand is padded to an even width so it splits into bit pairs.
  localparam int ROOT_W     = (RAW_W + 1) / 2;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 1;
  localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);
  localparam int STEP_W     = $clog2(2 * MAX_DIGITS + 2);
  localparam int EXT_W      = (ROOT_W > dsqrt_pkg::SCALED_W) ? ROOT_W : dsqrt_pkg::SCALED_W;

  localparam int IROOT_W    = dsqrt_pkg::INT_ROOT_W;
  localparam int IRAD_W     = dsqrt_pkg::INT_RAD_W;
  localparam int IREM_W     = IROOT_W + 1;

  dsqrt_pkg::state_e state_q, state_d;

  logic [dsqrt_pkg::DIGITS_W-1:0] digits_q;

  // Main unit: the radicand shift register first scales by ten each cycle,
  // then feeds two bits per cycle into the partial remainder.
  logic [RAD_W-1:0]      rad_q, rad_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [ROOT_W-1:0]     root_q, root_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [ROOT_CNT_W-1:0] root_cnt_q, root_cnt_d;

  // Integer root unit: the same bit-serial loop on the bare radicand.
  logic [IRAD_W-1:0]     irad_q, irad_d;
  logic [IREM_W-1:0]     irem_q, irem_d;
  logic [IROOT_W-1:0]    iroot_q, iroot_d;
  logic [dsqrt_pkg::INT_CNT_W-1:0] icnt_q, icnt_d;

  logic                  out_valid_q, out_valid_d;
  logic [dsqrt_pkg::M_TDATA_W-1:0] out_data_q, out_data_d;

  logic                  in_fire;
  logic [STEP_W-1:0]     steps_start;
  logic [ROOT_W+2:0]     rem_sh, trial, diff;
  logic                  take;
  logic [IREM_W+1:0]     irem_sh, itrial, idiff;
  logic                  itake;
  logic [EXT_W-1:0]      root_ext;
  logic                  out_free;

  assign s_axis_tready = (state_q == dsqrt_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Two scaling steps of ten per decimal digit; counts above the limit saturate.
  always_comb begin
    if (int'(digits_q) > MAX_DIGITS) begin
      steps_start = STEP_W'(2 * MAX_DIGITS);
    end else begin
      steps_start = STEP_W'(2 * int'(digits_q));
    end
  end

  // One restoring square root iteration of the main unit.
  always_comb begin
    rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    take   = (rem_sh >= trial);
    diff   = rem_sh - trial;
  end

  // One restoring square root iteration of the integer unit.
  always_comb begin
    irem_sh = {irem_q, irad_q[IRAD_W-1 -: 2]};
    itrial  = {1'b0, iroot_q, 2'b01};
    itake   = (irem_sh >= itrial);
    idiff   = irem_sh - itrial;
  end

  assign root_ext = EXT_W'(root_q);

  always_comb begin
    state_d     = state_q;
    rad_d       = rad_q;
    rem_d       = rem_q;
    root_d      = root_q;
    step_d      = step_q;
    root_cnt_d  = root_cnt_q;
    irad_d      = irad_q;
    irem_d      = irem_q;
    iroot_d     = iroot_q;
    icnt_d      = icnt_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    // The integer unit runs its 16 iterations alongside scaling and the main
    // loop; the main loop always lasts at least as long.
    if (icnt_q != '0) begin
      irad_d  = irad_q << 2;
      irem_d  = itake ? idiff[IREM_W-1:0] : irem_sh[IREM_W-1:0];
      iroot_d = {iroot_q[IROOT_W-2:0], itake};
      icnt_d  = icnt_q - 1'b1;
    end

    case (state_q)
      dsqrt_pkg::ST_IDLE: begin
        if (in_fire) begin
          rad_d      = RAD_W'(s_axis_tdata[dsqrt_pkg::RADICAND_W-1:0]);
          rem_d      = '0;
          root_d     = '0;
          step_d     = steps_start;
          root_cnt_d = ROOT_CNT_W'(ROOT_W);
          irad_d     = IRAD_W'(s_axis_tdata[dsqrt_pkg::RADICAND_W-1:0]);
          irem_d     = '0;
          iroot_d    = '0;
          icnt_d     = dsqrt_pkg::INT_CNT_W'(IROOT_W);
          state_d    = (steps_start == '0) ? dsqrt_pkg::ST_ROOT : dsqrt_pkg::ST_SCALE;
        end
      end
      dsqrt_pkg::ST_SCALE: begin
        // Multiply by ten as eight times plus two times.
        rad_d  = (rad_q << 3) + (rad_q << 1);
        step_d = step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          state_d = dsqrt_pkg::ST_ROOT;
        end
      end
      dsqrt_pkg::ST_ROOT: begin
        rad_d      = rad_q << 2;
        rem_d      = take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        root_d     = {root_q[ROOT_W-2:0], take};
        root_cnt_d = root_cnt_q - 1'b1;
        if (root_cnt_q == ROOT_CNT_W'(1)) begin
          state_d = dsqrt_pkg::ST_DONE;
        end
      end
      dsqrt_pkg::ST_DONE: begin
        // Hand the result over once the output register is free.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {4'b0000, root_ext[dsqrt_pkg::SCALED_W-1:0], iroot_q};
          state_d     = dsqrt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dsqrt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsqrt_pkg::ST_IDLE;
      digits_q    <= dsqrt_pkg::DIGITS_RESET;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      root_cnt_q  <= '0;
      icnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      root_cnt_q  <= root_cnt_d;
      icnt_q      <= icnt_d;
      if (cfg_wr_en_i) begin
        digits_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q      <= rad_d;
    rem_q      <= rem_d;
    root_q     <= root_d;
    irad_q     <= irad_d;
    irem_q     <= irem_d;
    iroot_q    <= iroot_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
